// ----- hw/rtl/llas_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the life-like automaton step unit.
// Used by llas_cell, llas_switch_counter and life_like_automaton_step_unit.
package llas_pkg;

	localparam int unsigned ROW_BITS   = 64;
	localparam int unsigned MASK_W     = 9;
	localparam int unsigned COUNT_W    = 13;
	localparam int unsigned SUM_W      = 4;
	localparam int unsigned COL_SUM_W  = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

	localparam logic [1:0] OP_STEP   = 2'd0;
	localparam logic [1:0] OP_TOGGLE = 2'd1;
	localparam logic [1:0] OP_WRITE  = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic REG_BIRTH   = 1'b0;
	localparam logic REG_SURVIVE = 1'b1;

	localparam logic [MASK_W-1:0] BIRTH_RESET   = 9'd8;
	localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'd12;

	typedef struct packed {
		logic [1:0]          opcode;
		logic [5:0]          cell_column;
		logic [5:0]          cell_row;
		logic [ROW_BITS-1:0] row_data;
	} cmd_t;

	typedef struct packed {
		logic [ROW_BITS-1:0] row_bits;
		logic                stable;
		logic [COUNT_W-1:0]  switched_count;
	} result_t;

	typedef struct packed {
		logic [MASK_W-1:0] birth;
		logic [MASK_W-1:0] survive;
	} rule_t;

	typedef struct packed {
		logic clear;
		logic valid;
		logic last;
	} count_ctl_t;

endpackage

// ----- hw/rtl/llas_cell.sv -----
`timescale 1ns / 1ps
// One column cell: holds a three-row window of its column and computes the
// next state of its middle cell. Depends on llas_pkg.
module llas_cell (
	input  logic                              clk,
	input  logic                              shift,
	input  logic                              in_bit,
	input  logic [llas_pkg::COL_SUM_W-1:0]    left_sum,
	input  logic [llas_pkg::COL_SUM_W-1:0]    right_sum,
	input  llas_pkg::rule_t                   rule,
	output logic [llas_pkg::COL_SUM_W-1:0]    col_sum,
	output logic                              next_bit,
	output logic                              changed
);

	logic                        up_q;
	logic                        mid_q;
	logic                        down_q;
	logic [llas_pkg::SUM_W-1:0]  count;

	always_ff @(posedge clk) begin
		if (shift) begin
			up_q   <= mid_q;
			mid_q  <= down_q;
			down_q <= in_bit;
		end
	end

	// The vertical sum of this column is handed to both neighbors.
	assign col_sum = {1'b0, up_q} + {1'b0, mid_q} + {1'b0, down_q};

	assign count = {2'b00, left_sum} + {2'b00, right_sum}
		+ {3'b000, up_q} + {3'b000, down_q};

	assign next_bit = mid_q ? rule.survive[count] : rule.birth[count];
	assign changed  = next_bit ^ mid_q;

endmodule

// ----- hw/rtl/llas_switch_counter.sv -----
`timescale 1ns / 1ps
// Counts the cells switched during one generation, one row per cycle,
// through a registered adder tree and a saturating accumulator. Depends on llas_pkg.
module llas_switch_counter #(
	parameter int unsigned COLUMNS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  llas_pkg::count_ctl_t           ctl,
	input  logic [COLUMNS-1:0]             changed,
	output logic                           finish,
	output logic [llas_pkg::COUNT_W-1:0]   total
);

	localparam int unsigned NUM_GROUPS = (COLUMNS + 7) / 8;
	localparam int unsigned PAD_W      = NUM_GROUPS * 8;

	logic [PAD_W-1:0]                chg_s3;
	logic                            valid_s3;
	logic                            last_s3;
	logic [llas_pkg::SUM_W-1:0]      grp_s4 [NUM_GROUPS];
	logic                            valid_s4;
	logic                            last_s4;
	logic [llas_pkg::COUNT_W-1:0]    acc_q;
	logic [llas_pkg::SUM_W-1:0]      grp_sum [NUM_GROUPS];
	logic [6:0]                      row_sum;
	logic [llas_pkg::COUNT_W:0]      acc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			last_s3  <= 1'b0;
			valid_s4 <= 1'b0;
			last_s4  <= 1'b0;
		end else begin
			valid_s3 <= ctl.valid;
			last_s3  <= ctl.valid && ctl.last;
			valid_s4 <= valid_s3;
			last_s4  <= valid_s3 && last_s3;
		end
	end

	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			grp_sum[g] = '0;
			for (int j = 0; j < 8; j++) begin
				grp_sum[g] = grp_sum[g] + {3'b000, chg_s3[g*8+j]};
			end
		end
	end

	always_ff @(posedge clk) begin
		chg_s3 <= PAD_W'(changed);
		for (int g = 0; g < NUM_GROUPS; g++) begin
			grp_s4[g] <= grp_sum[g];
		end
	end

	always_comb begin
		row_sum = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			row_sum = row_sum + {3'b000, grp_s4[g]};
		end
	end

	assign acc_next = {1'b0, acc_q} + {{(llas_pkg::COUNT_W - 6){1'b0}}, row_sum};

	// Saturates at the largest count the result field can hold.
	always_comb begin
		if (!valid_s4) begin
			total = acc_q;
		end else if (acc_next > {1'b0, llas_pkg::COUNT_MAX}) begin
			total = llas_pkg::COUNT_MAX;
		end else begin
			total = acc_next[llas_pkg::COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (valid_s4) begin
			acc_q <= total;
		end
	end

	assign finish = valid_s4 && last_s4;

endmodule

// ----- hw/rtl/life_like_automaton_step_unit.sv -----
`timescale 1ns / 1ps
// Top level of the life-like automaton step unit: grid memory, sequencer
// and the row of column cells. Depends on llas_pkg, llas_cell, llas_switch_counter.
//
// Timing for users: after reset the unit clears the grid memory, one row per
// cycle, and holds busy high while it does so. A command is taken at a
// clock edge with start high and busy low. A row write returns its result
// in the next cycle and busy stays low, so writes can follow every cycle. A
// toggle or row read returns its result through the registered read of the
// grid memory and the access state. For a generation step the memory feeds
// GRID_ROWS + 2 rows, one per cycle, through the column cells, and the
// switched-cell count drains through a registered adder pipeline. Each
// result is shown for one cycle with done high and cannot be held off.
module life_like_automaton_step_unit #(
	parameter int unsigned GRID_COLUMNS = 64,
	parameter int unsigned GRID_ROWS    = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  llas_pkg::cmd_t                cmd,
	output logic                          done,
	output llas_pkg::result_t             result,
	input  logic                          cfg_write,
	input  logic                          cfg_index,
	input  logic [llas_pkg::MASK_W-1:0]   cfg_data
);

	localparam int unsigned ADDR_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int unsigned SEQ_W  = $clog2(GRID_ROWS + 3);
	localparam logic [SEQ_W-1:0]  LAST_FEED = SEQ_W'(GRID_ROWS + 1);
	localparam logic [SEQ_W-1:0]  LAST_CLR  = SEQ_W'(GRID_ROWS - 1);
	localparam logic [ADDR_W-1:0] LAST_ROW  = ADDR_W'(GRID_ROWS - 1);

	typedef enum logic [3:0] {
		S_CLEAR  = 4'b0001,
		S_IDLE   = 4'b0010,
		S_STEP   = 4'b0100,
		S_ACCESS = 4'b1000
	} state_t;

	state_t                           state_q;
	logic [SEQ_W-1:0]                 seq_q;
	llas_pkg::rule_t                  rule_q;
	llas_pkg::cmd_t                   cmd_q;
	llas_pkg::result_t                result_q;
	logic                             done_q;

	logic [GRID_COLUMNS-1:0]          mem [GRID_ROWS];
	logic [GRID_COLUMNS-1:0]          rd_data_q;
	logic [GRID_COLUMNS-1:0]          row0_q;

	logic                             feed_v_s1;
	logic                             saved_s1;
	logic                             first_s1;
	logic                             comp_s1;
	logic                             last_s1;
	logic [ADDR_W-1:0]                row_s1;
	logic                             comp_s2;
	logic                             last_s2;
	logic [ADDR_W-1:0]                row_s2;

	logic                             accept;
	logic                             feed_go;
	logic                             row_ok;
	logic                             row_ok_q;
	logic                             col_ok_q;
	logic [ADDR_W-1:0]                rd_addr;
	logic                             wr_en;
	logic [ADDR_W-1:0]                wr_addr;
	logic [GRID_COLUMNS-1:0]          wr_data;
	logic [GRID_COLUMNS-1:0]          toggled;
	logic [GRID_COLUMNS-1:0]          shift_row;
	logic [GRID_COLUMNS-1:0]          next_row;
	logic [GRID_COLUMNS-1:0]          changed_row;
	logic [llas_pkg::COL_SUM_W-1:0]   col_sum [GRID_COLUMNS];
	llas_pkg::count_ctl_t             cnt_ctl;
	logic                             cnt_finish;
	logic [llas_pkg::COUNT_W-1:0]     cnt_total;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	assign row_ok   = (32'(cmd.cell_row) < GRID_ROWS);
	assign row_ok_q = (32'(cmd_q.cell_row) < GRID_ROWS);
	assign col_ok_q = (32'(cmd_q.cell_column) < GRID_COLUMNS);

	// Feeds the rows last, 0, 1, ..., last and then the saved first row.
	assign feed_go = (state_q == S_STEP) && (seq_q <= LAST_FEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q.birth   <= llas_pkg::BIRTH_RESET;
			rule_q.survive <= llas_pkg::SURVIVE_RESET;
		end else if (cfg_write) begin
			if (cfg_index == llas_pkg::REG_BIRTH) begin
				rule_q.birth <= cfg_data;
			end else begin
				rule_q.survive <= cfg_data;
			end
		end
	end

	always_comb begin
		rd_addr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (row_ok) begin
					rd_addr = ADDR_W'(cmd.cell_row);
				end
			end
			S_STEP: begin
				if (seq_q == '0) begin
					rd_addr = LAST_ROW;
				end else if (seq_q <= SEQ_W'(GRID_ROWS)) begin
					rd_addr = ADDR_W'(seq_q - SEQ_W'(1));
				end
			end
			S_CLEAR, S_ACCESS: begin
				rd_addr = '0;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	assign toggled = rd_data_q
		^ (col_ok_q ? (GRID_COLUMNS'(1) << cmd_q.cell_column) : '0);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = ADDR_W'(seq_q);
			end
			S_IDLE: begin
				wr_en   = accept && (cmd.opcode == llas_pkg::OP_WRITE) && row_ok;
				wr_addr = ADDR_W'(cmd.cell_row);
				wr_data = GRID_COLUMNS'(cmd.row_data);
			end
			S_ACCESS: begin
				wr_en   = (cmd_q.opcode == llas_pkg::OP_TOGGLE) && row_ok_q;
				wr_addr = ADDR_W'(cmd_q.cell_row);
				wr_data = toggled;
			end
			S_STEP: begin
				wr_en   = comp_s2;
				wr_addr = row_s2;
				wr_data = next_row;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			seq_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					done_q <= 1'b0;
					if (seq_q == LAST_CLR) begin
						state_q <= S_IDLE;
						seq_q   <= '0;
					end else begin
						seq_q <= seq_q + SEQ_W'(1);
					end
				end
				S_IDLE: begin
					done_q <= accept && (cmd.opcode == llas_pkg::OP_WRITE);
					if (accept) begin
						seq_q <= '0;
						unique case (cmd.opcode)
							llas_pkg::OP_STEP:  state_q <= S_STEP;
							llas_pkg::OP_WRITE: state_q <= S_IDLE;
							default:            state_q <= S_ACCESS;
						endcase
					end
				end
				S_STEP: begin
					done_q <= cnt_finish;
					if (feed_go) begin
						seq_q <= seq_q + SEQ_W'(1);
					end
					if (cnt_finish) begin
						state_q <= S_IDLE;
					end
				end
				S_ACCESS: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		if (feed_v_s1 && first_s1) begin
			row0_q <= rd_data_q;
		end
		if (state_q == S_STEP) begin
			result_q.row_bits       <= '0;
			result_q.stable         <= (cnt_total == '0);
			result_q.switched_count <= cnt_total;
		end else if (state_q == S_ACCESS) begin
			result_q.stable         <= 1'b0;
			result_q.switched_count <= '0;
			if (!row_ok_q) begin
				result_q.row_bits <= '0;
			end else if (cmd_q.opcode == llas_pkg::OP_TOGGLE) begin
				result_q.row_bits <= llas_pkg::ROW_BITS'(toggled);
			end else begin
				result_q.row_bits <= llas_pkg::ROW_BITS'(rd_data_q);
			end
		end else begin
			result_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_v_s1 <= 1'b0;
			comp_s1   <= 1'b0;
			last_s1   <= 1'b0;
			comp_s2   <= 1'b0;
			last_s2   <= 1'b0;
		end else begin
			feed_v_s1 <= feed_go;
			comp_s1   <= feed_go && (seq_q >= SEQ_W'(2));
			last_s1   <= feed_go && (seq_q == LAST_FEED);
			comp_s2   <= feed_v_s1 && comp_s1;
			last_s2   <= feed_v_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		saved_s1 <= (seq_q == LAST_FEED);
		first_s1 <= (seq_q == SEQ_W'(1));
		row_s1   <= ADDR_W'(seq_q - SEQ_W'(2));
		row_s2   <= row_s1;
	end

	// The original first row is overwritten early, so the wrap row comes from a copy.
	assign shift_row = saved_s1 ? row0_q : rd_data_q;

	for (genvar c = 0; c < GRID_COLUMNS; c++) begin : g_cell
		localparam int unsigned LEFT  = (c == 0) ? GRID_COLUMNS - 1 : c - 1;
		localparam int unsigned RIGHT = (c == GRID_COLUMNS - 1) ? 0 : c + 1;
		llas_cell u_cell (
			.clk       (clk),
			.shift     (feed_v_s1),
			.in_bit    (shift_row[c]),
			.left_sum  (col_sum[LEFT]),
			.right_sum (col_sum[RIGHT]),
			.rule      (rule_q),
			.col_sum   (col_sum[c]),
			.next_bit  (next_row[c]),
			.changed   (changed_row[c])
		);
	end

	assign cnt_ctl.clear = accept && (cmd.opcode == llas_pkg::OP_STEP);
	assign cnt_ctl.valid = comp_s2;
	assign cnt_ctl.last  = last_s2;

	llas_switch_counter #(
		.COLUMNS (GRID_COLUMNS)
	) u_counter (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (cnt_ctl),
		.changed (changed_row),
		.finish  (cnt_finish),
		.total   (cnt_total)
	);

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a command is still in progress");

	a_compute_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		comp_s2 |-> (state_q == S_STEP))
		else $error("row computed outside a generation step");

	a_finish_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_finish |-> (state_q == S_STEP))
		else $error("switch count finished outside a generation step");

	a_stable_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.stable) |-> (result.switched_count == '0))
		else $error("stable reported with a nonzero switch count");

	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.opcode == llas_pkg::OP_STEP)) |=> busy)
		else $error("generation step accepted without raising busy");

endmodule
